/* design/vncs_pkg.sv */
package vncs_pkg;

  localparam int IFRAC     = 28;
  localparam int FRAC_BITS = 14;
  localparam int RAND_BITS = 16;

  // root widths of the two square-root chains and quotient bits of the divider
  localparam int SQ1_K  = 29;
  localparam int SQ2_K  = 31;
  localparam int DIV_QW = FRAC_BITS + 1;

  typedef logic signed [31:0] fx_t;

  localparam fx_t      ONE_I    = 32'sd268435456;
  localparam logic [30:0] TWO_PI_I = 31'd1686629714;

  // Horner coefficients on one octant, 28 fraction bits
  localparam fx_t SIN_SEED = 32'sd740;
  localparam fx_t COS_SEED = -32'sd74;
  localparam fx_t SIN_C [4] = '{-32'sd53261, 32'sd2236962, -32'sd44739243, 32'sd268435456};
  localparam fx_t COS_C [4] = '{32'sd6658, -32'sd372827, 32'sd11184811, -32'sd134217728};

  typedef struct packed {
    fx_t         wx;
    fx_t         wy;
    fx_t         wz;
    fx_t         z;
    logic [28:0] rem;
  } carry_t;

  // product truncated toward minus infinity
  function automatic fx_t qmul(input fx_t a, input fx_t b);
    logic signed [63:0] p;
    p = a * b;
    return fx_t'(p >>> IFRAC);
  endfunction

endpackage

/* design/vncs_sqrt_cell.sv */
module vncs_sqrt_cell #(
  parameter int K  = 29,
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  logic [2*K-1:0] rad_i,
  input  logic [K:0]     rem_i,
  input  logic [K-1:0]   root_i,
  input  logic [SW-1:0]  side_i,
  output logic           vld_o,
  output logic [2*K-1:0] rad_o,
  output logic [K:0]     rem_o,
  output logic [K-1:0]   root_o,
  output logic [SW-1:0]  side_o
);

  logic           vld_r;
  logic [2*K-1:0] rad_r;
  logic [K:0]     rem_r;
  logic [K-1:0]   root_r;
  logic [SW-1:0]  side_r;
  logic [K+2:0]   cur;
  logic [K+2:0]   trial;
  logic           take;

  // one root bit per cell: bring down two radicand bits, try 4*root+1
  assign cur   = {rem_i, rad_i[2*K-1 -: 2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign take  = (cur >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_i << 2;
      rem_r  <= take ? (K+1)'(cur - trial) : (K+1)'(cur);
      root_r <= {root_i[K-2:0], take};
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

/* design/vncs_div_cell.sv */
module vncs_div_cell #(
  parameter int DW = 31,
  parameter int QW = 15,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [DW-1:0] den_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [QW-1:0] quo_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [DW-1:0] den_o,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] low_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          vld_r;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r;
  logic [QW-1:0] low_r;
  logic [QW-1:0] quo_r;
  logic [SW-1:0] side_r;
  logic [DW:0]   cur;
  logic          take;

  // restoring step: shift in the next numerator bit, subtract if it fits
  assign cur  = {rem_i, low_i[QW-1]};
  assign take = (cur >= {1'b0, den_i});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= den_i;
      rem_r  <= take ? DW'(cur - {1'b0, den_i}) : DW'(cur);
      low_r  <= low_i << 1;
      quo_r  <= {quo_i[QW-2:0], take};
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign den_o  = den_r;
  assign rem_o  = rem_r;
  assign low_o  = low_r;
  assign quo_o  = quo_r;
  assign side_o = side_r;

endmodule

/* design/visible_normal_cap_sampler.sv */
// channel | direction | handshake          | word
// in      | input     | in_valid/in_ready  | view x,y,z (Q2.14), u_phi, u_cap
// out     | output    | out_valid/out_ready| normal x,y,z (Q2.14), degenerate
//
// One word accepted per cycle while the output is not stalled, one result per word.
// The pipe is made of the two square-root chains (29 and 31 cells, one root bit
// each) and the 15-cell divider chain, plus 14 arithmetic stages.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
// A stalled output freezes the whole pipe; in_ready = !out_valid | out_ready.
module visible_normal_cap_sampler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_view_x,
  input  logic signed [15:0] in_view_y,
  input  logic signed [15:0] in_view_z,
  input  logic [15:0]        in_u_phi,
  input  logic [15:0]        in_u_cap,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic               out_degenerate
);
  import vncs_pkg::*;

  localparam int S1W = 64 + $bits(carry_t);
  localparam int S2W = 96;

  function automatic fx_t view_in(input logic signed [15:0] v);
    fx_t e;
    e = fx_t'(v) <<< (IFRAC - FRAC_BITS);
    if (e > ONE_I) begin
      e = ONE_I;
    end else if (e < -ONE_I) begin
      e = -ONE_I;
    end
    return e;
  endfunction

  function automatic logic [27:0] frac_in(input logic [15:0] u);
    logic [63:0] w;
    w = (64'(u) & ((64'd1 << RAND_BITS) - 64'd1)) << IFRAC;
    return 28'(w >> RAND_BITS);
  endfunction

  function automatic logic [29:0] abs30(input fx_t v);
    return (v < 0) ? 30'(-v) : 30'(v);
  endfunction

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage A: input conversion, octant fold
  logic [27:0] t_phi, t_cap;
  logic [25:0] f_oct;
  logic        swap_nxt;
  fx_t         wz_nxt;

  assign t_phi    = frac_in(in_u_phi);
  assign t_cap    = frac_in(in_u_cap);
  assign f_oct    = t_phi[25:0];
  assign swap_nxt = (f_oct > 26'd33554432);
  assign wz_nxt   = view_in(in_view_z);

  logic        vld_a_r, swap_a_r;
  logic [1:0]  q_a_r;
  logic [25:0] ang_a_r;
  logic [28:0] omu_a_r;
  logic [29:0] opw_a_r;
  fx_t         wx_a_r, wy_a_r, wz_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx_a_r   <= view_in(in_view_x);
      wy_a_r   <= view_in(in_view_y);
      wz_a_r   <= wz_nxt;
      q_a_r    <= t_phi[27:26];
      swap_a_r <= swap_nxt;
      ang_a_r  <= swap_nxt ? 26'(27'd67108864 - 27'(f_oct)) : f_oct;
      omu_a_r  <= 29'(ONE_I - fx_t'({4'b0, t_cap}));
      opw_a_r  <= 30'(wz_nxt + ONE_I);
    end
  end

  // stage B: angle in radians, cap height
  logic [56:0] ang_prod;
  logic [58:0] z_prod;
  assign ang_prod = 57'(ang_a_r) * 57'(TWO_PI_I);
  assign z_prod   = 59'(omu_a_r) * 59'(opw_a_r);

  logic        vld_b_r, swap_b_r;
  logic [1:0]  q_b_r;
  fx_t         x_b_r, z_b_r, wx_b_r, wy_b_r, wz_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_b_r    <= fx_t'({4'b0, ang_prod[IFRAC +: 28]});
      z_b_r    <= fx_t'(z_prod >> IFRAC) - wz_a_r;
      wx_b_r   <= wx_a_r;
      wy_b_r   <= wy_a_r;
      wz_b_r   <= wz_a_r;
      q_b_r    <= q_a_r;
      swap_b_r <= swap_a_r;
    end
  end

  // stage C: x^2 and 1 - z^2
  fx_t rem_raw;
  assign rem_raw = ONE_I - qmul(z_b_r, z_b_r);

  logic        vld_c_r, swap_c_r;
  logic [1:0]  q_c_r;
  fx_t         x_c_r, x2_c_r;
  carry_t      cy_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
    end else if (en) begin
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_c_r     <= x_b_r;
      x2_c_r    <= qmul(x_b_r, x_b_r);
      q_c_r     <= q_b_r;
      swap_c_r  <= swap_b_r;
      cy_c_r.wx <= wx_b_r;
      cy_c_r.wy <= wy_b_r;
      cy_c_r.wz <= wz_b_r;
      cy_c_r.z  <= z_b_r;
      if (rem_raw < 0) begin
        cy_c_r.rem <= '0;
      end else if (rem_raw > ONE_I) begin
        cy_c_r.rem <= 29'(ONE_I);
      end else begin
        cy_c_r.rem <= 29'(rem_raw);
      end
    end
  end

  // Horner stages, one multiply per polynomial per stage
  logic        vld_p_r  [4];
  logic        swap_p_r [4];
  logic [1:0]  q_p_r    [4];
  fx_t         x_p_r    [4];
  fx_t         x2_p_r   [4];
  fx_t         ps_p_r   [4];
  fx_t         pc_p_r   [4];
  carry_t      cy_p_r   [4];

  for (genvar k = 0; k < 4; k++) begin : g_poly
    logic   vld_in, swap_in;
    logic [1:0] q_in;
    fx_t    x_in, x2_in, ps_in, pc_in;
    carry_t cy_in;

    if (k == 0) begin : g_first
      assign vld_in  = vld_c_r;
      assign swap_in = swap_c_r;
      assign q_in    = q_c_r;
      assign x_in    = x_c_r;
      assign x2_in   = x2_c_r;
      assign ps_in   = SIN_SEED;
      assign pc_in   = COS_SEED;
      assign cy_in   = cy_c_r;
    end else begin : g_next
      assign vld_in  = vld_p_r[k-1];
      assign swap_in = swap_p_r[k-1];
      assign q_in    = q_p_r[k-1];
      assign x_in    = x_p_r[k-1];
      assign x2_in   = x2_p_r[k-1];
      assign ps_in   = ps_p_r[k-1];
      assign pc_in   = pc_p_r[k-1];
      assign cy_in   = cy_p_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_p_r[k] <= 1'b0;
      end else if (en) begin
        vld_p_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        swap_p_r[k] <= swap_in;
        q_p_r[k]    <= q_in;
        x_p_r[k]    <= x_in;
        x2_p_r[k]   <= x2_in;
        ps_p_r[k]   <= SIN_C[k] + qmul(x2_in, ps_in);
        pc_p_r[k]   <= COS_C[k] + qmul(x2_in, pc_in);
        cy_p_r[k]   <= cy_in;
      end
    end
  end

  // stage E: final sin/cos products
  logic        vld_e_r, swap_e_r;
  logic [1:0]  q_e_r;
  fx_t         sn_e_r, cs_e_r;
  carry_t      cy_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_e_r <= 1'b0;
    end else if (en) begin
      vld_e_r <= vld_p_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn_e_r   <= qmul(x_p_r[3], ps_p_r[3]);
      cs_e_r   <= ONE_I + qmul(x2_p_r[3], pc_p_r[3]);
      swap_e_r <= swap_p_r[3];
      q_e_r    <= q_p_r[3];
      cy_e_r   <= cy_p_r[3];
    end
  end

  // stage F: unfold octant and quadrant
  fx_t s_oct, c_oct, sphi_nxt, cphi_nxt;
  assign s_oct = swap_e_r ? cs_e_r : sn_e_r;
  assign c_oct = swap_e_r ? sn_e_r : cs_e_r;

  always_comb begin
    case (q_e_r)
      2'd0:    begin cphi_nxt = c_oct;  sphi_nxt = s_oct;  end
      2'd1:    begin cphi_nxt = -s_oct; sphi_nxt = c_oct;  end
      2'd2:    begin cphi_nxt = -c_oct; sphi_nxt = -s_oct; end
      default: begin cphi_nxt = s_oct;  sphi_nxt = -c_oct; end
    endcase
  end

  logic   vld_f_r;
  fx_t    sphi_f_r, cphi_f_r;
  carry_t cy_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_f_r <= 1'b0;
    end else if (en) begin
      vld_f_r <= vld_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sphi_f_r <= sphi_nxt;
      cphi_f_r <= cphi_nxt;
      cy_f_r   <= cy_e_r;
    end
  end

  // cap radius = isqrt(rem << 28)
  logic               s1_vld  [SQ1_K+1];
  logic [2*SQ1_K-1:0] s1_rad  [SQ1_K+1];
  logic [SQ1_K:0]     s1_rem  [SQ1_K+1];
  logic [SQ1_K-1:0]   s1_root [SQ1_K+1];
  logic [S1W-1:0]     s1_side [SQ1_K+1];

  assign s1_vld[0]  = vld_f_r;
  assign s1_rad[0]  = {1'b0, cy_f_r.rem, 28'b0};
  assign s1_rem[0]  = '0;
  assign s1_root[0] = '0;
  assign s1_side[0] = {sphi_f_r, cphi_f_r, cy_f_r};

  for (genvar i = 0; i < SQ1_K; i++) begin : g_sq1
    vncs_sqrt_cell #(.K(SQ1_K), .SW(S1W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (s1_vld[i]),
      .rad_i  (s1_rad[i]),
      .rem_i  (s1_rem[i]),
      .root_i (s1_root[i]),
      .side_i (s1_side[i]),
      .vld_o  (s1_vld[i+1]),
      .rad_o  (s1_rad[i+1]),
      .rem_o  (s1_rem[i+1]),
      .root_o (s1_root[i+1]),
      .side_o (s1_side[i+1])
    );
  end

  // stage G: add the cap point to the view
  fx_t    sphi_g, cphi_g, sin_g;
  carry_t cy_g;
  assign {sphi_g, cphi_g, cy_g} = s1_side[SQ1_K];
  assign sin_g = fx_t'({3'b0, s1_root[SQ1_K]});

  logic vld_g_r;
  fx_t  sx_g_r, sy_g_r, sz_g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_g_r <= 1'b0;
    end else if (en) begin
      vld_g_r <= s1_vld[SQ1_K];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_g_r <= cy_g.wx + qmul(sin_g, cphi_g);
      sy_g_r <= cy_g.wy + qmul(sin_g, sphi_g);
      sz_g_r <= cy_g.wz + cy_g.z;
    end
  end

  // stage H: squares
  logic [29:0] ax_h, ay_h, az_h;
  assign ax_h = abs30(sx_g_r);
  assign ay_h = abs30(sy_g_r);
  assign az_h = abs30(sz_g_r);

  logic        vld_h_r;
  logic [59:0] qx_h_r, qy_h_r, qz_h_r;
  fx_t         sx_h_r, sy_h_r, sz_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_h_r <= 1'b0;
    end else if (en) begin
      vld_h_r <= vld_g_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx_h_r <= 60'(ax_h) * 60'(ax_h);
      qy_h_r <= 60'(ay_h) * 60'(ay_h);
      qz_h_r <= 60'(az_h) * 60'(az_h);
      sx_h_r <= sx_g_r;
      sy_h_r <= sy_g_r;
      sz_h_r <= sz_g_r;
    end
  end

  // stage I: squared length
  logic               vld_i_r;
  logic [2*SQ2_K-1:0] len2_i_r;
  fx_t                sx_i_r, sy_i_r, sz_i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_i_r <= 1'b0;
    end else if (en) begin
      vld_i_r <= vld_h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len2_i_r <= 62'(qx_h_r) + 62'(qy_h_r) + 62'(qz_h_r);
      sx_i_r   <= sx_h_r;
      sy_i_r   <= sy_h_r;
      sz_i_r   <= sz_h_r;
    end
  end

  // length = isqrt(len2)
  logic               s2_vld  [SQ2_K+1];
  logic [2*SQ2_K-1:0] s2_rad  [SQ2_K+1];
  logic [SQ2_K:0]     s2_rem  [SQ2_K+1];
  logic [SQ2_K-1:0]   s2_root [SQ2_K+1];
  logic [S2W-1:0]     s2_side [SQ2_K+1];

  assign s2_vld[0]  = vld_i_r;
  assign s2_rad[0]  = len2_i_r;
  assign s2_rem[0]  = '0;
  assign s2_root[0] = '0;
  assign s2_side[0] = {sx_i_r, sy_i_r, sz_i_r};

  for (genvar i = 0; i < SQ2_K; i++) begin : g_sq2
    vncs_sqrt_cell #(.K(SQ2_K), .SW(S2W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (s2_vld[i]),
      .rad_i  (s2_rad[i]),
      .rem_i  (s2_rem[i]),
      .root_i (s2_root[i]),
      .side_i (s2_side[i]),
      .vld_o  (s2_vld[i+1]),
      .rad_o  (s2_rad[i+1]),
      .rem_o  (s2_rem[i+1]),
      .root_o (s2_root[i+1]),
      .side_o (s2_side[i+1])
    );
  end

  // stage J: rounded numerators; top part already below len
  fx_t            sv_j [3];
  logic [SQ2_K-1:0] len_j;
  assign {sv_j[0], sv_j[1], sv_j[2]} = s2_side[SQ2_K];
  assign len_j = s2_root[SQ2_K];

  logic             vld_j_r, degen_j_r;
  logic [SQ2_K-1:0] len_j_r;
  logic [SQ2_K-1:0] rem_j_r  [3];
  logic [DIV_QW-1:0] low_j_r [3];
  logic             sgn_j_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_j_r <= 1'b0;
    end else if (en) begin
      vld_j_r <= s2_vld[SQ2_K];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_num
    logic [45:0] num;
    assign num = (46'(abs30(sv_j[l])) << FRAC_BITS) + 46'(len_j >> 1);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_j_r[l] <= SQ2_K'(num >> DIV_QW);
        low_j_r[l] <= num[DIV_QW-1:0];
        sgn_j_r[l] <= sv_j[l][31];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_j_r   <= len_j;
      degen_j_r <= (len_j == '0);
    end
  end

  // divider lanes; lane x carries the valid bit and the degenerate flag
  logic [DIV_QW-1:0] quo_end [3];
  logic              sgn_end [3];
  logic              vld_end, degen_end;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    localparam int SW = (l == 0) ? 2 : 1;
    logic              d_vld  [DIV_QW+1];
    logic [SQ2_K-1:0]  d_den  [DIV_QW+1];
    logic [SQ2_K-1:0]  d_rem  [DIV_QW+1];
    logic [DIV_QW-1:0] d_low  [DIV_QW+1];
    logic [DIV_QW-1:0] d_quo  [DIV_QW+1];
    logic [SW-1:0]     d_side [DIV_QW+1];

    assign d_vld[0] = vld_j_r;
    assign d_den[0] = len_j_r;
    assign d_rem[0] = rem_j_r[l];
    assign d_low[0] = low_j_r[l];
    assign d_quo[0] = '0;
    if (l == 0) begin : g_side_x
      assign d_side[0] = {sgn_j_r[l], degen_j_r};
      assign degen_end  = d_side[DIV_QW][0];
      assign vld_end    = d_vld[DIV_QW];
    end else begin : g_side_yz
      assign d_side[0] = sgn_j_r[l];
    end
    assign sgn_end[l] = d_side[DIV_QW][SW-1];
    assign quo_end[l] = d_quo[DIV_QW];

    for (genvar i = 0; i < DIV_QW; i++) begin : g_cell
      vncs_div_cell #(.DW(SQ2_K), .QW(DIV_QW), .SW(SW)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vld_i  (d_vld[i]),
        .den_i  (d_den[i]),
        .rem_i  (d_rem[i]),
        .low_i  (d_low[i]),
        .quo_i  (d_quo[i]),
        .side_i (d_side[i]),
        .vld_o  (d_vld[i+1]),
        .den_o  (d_den[i+1]),
        .rem_o  (d_rem[i+1]),
        .low_o  (d_low[i+1]),
        .quo_o  (d_quo[i+1]),
        .side_o (d_side[i+1])
      );
    end
  end

  // output register: limit, sign, degenerate override
  localparam logic [DIV_QW-1:0] MAG_MAX = DIV_QW'(1) << FRAC_BITS;

  logic signed [15:0] nrm_nxt [3];
  for (genvar l = 0; l < 3; l++) begin : g_out
    logic [DIV_QW-1:0] mag;
    assign mag = (quo_end[l] > MAG_MAX) ? MAG_MAX : quo_end[l];
    assign nrm_nxt[l] = degen_end ? 16'sd0 :
                        sgn_end[l] ? -$signed(16'(mag)) : $signed(16'(mag));
  end

  logic               out_valid_r, out_degenerate_r;
  logic signed [15:0] out_normal_x_r, out_normal_y_r, out_normal_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_end;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_normal_x_r   <= nrm_nxt[0];
      out_normal_y_r   <= nrm_nxt[1];
      out_normal_z_r   <= nrm_nxt[2];
      out_degenerate_r <= degen_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = out_normal_x_r;
  assign out_normal_y   = out_normal_y_r;
  assign out_normal_z   = out_normal_z_r;
  assign out_degenerate = out_degenerate_r;

endmodule

/* design/vncs_checker.sv */
module vncs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [15:0] in_view_x,
  input logic signed [15:0] in_view_y,
  input logic signed [15:0] in_view_z,
  input logic [15:0]        in_u_phi,
  input logic [15:0]        in_u_cap,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_normal_x,
  input logic signed [15:0] out_normal_y,
  input logic signed [15:0] out_normal_z,
  input logic               out_degenerate
);
  import vncs_pkg::*;

  localparam logic signed [15:0] LIM = 16'sd1 <<< FRAC_BITS;

  // a waiting input word stays put until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=> (in_valid && $stable(in_view_x) && $stable(in_view_y)
      && $stable(in_view_z) && $stable(in_u_phi) && $stable(in_u_cap)))
    else $error("waiting input word changed");

  // pipe only stalls on a held output word
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled without output back-pressure");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_normal_x)
      && $stable(out_normal_y) && $stable(out_normal_z) && $stable(out_degenerate)))
    else $error("stalled output word changed");

  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_normal_x == 0 && out_normal_y == 0 && out_normal_z == 0))
    else $error("degenerate word with nonzero normal");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_normal_x <= LIM && out_normal_x >= -LIM &&
                   out_normal_y <= LIM && out_normal_y >= -LIM &&
                   out_normal_z <= LIM && out_normal_z >= -LIM))
    else $error("normal component beyond unit range");

endmodule

bind visible_normal_cap_sampler vncs_checker u_vncs_checker (.*);
